// File: hw/rtl/rgrr_pkg.sv
`default_nettype none
package rgrr_pkg;

  localparam int MAX_OUT_GATES_DEF = 4096;
  localparam int MAX_FANOUT_DEF    = 16;
  localparam int SLOTS_PER_GATE    = 4;
  localparam int TABLE_DEPTH       = 256;
  localparam int NUM_TABLES        = 3;

  localparam int SLOT_W      = $clog2(SLOTS_PER_GATE);
  localparam int BYTE_W      = $clog2(TABLE_DEPTH);
  localparam int TBL_W       = $clog2(NUM_TABLES);
  localparam int ADDR_W      = TBL_W + BYTE_W;
  localparam int TAB_ENTRIES = NUM_TABLES * TABLE_DEPTH;

  localparam int OUT_GATE_W = 12;
  localparam int OGC_W      = 13;
  localparam int SPACING_W  = 16;
  localparam int EDGE_W     = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_GATE_W - BYTE_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_TABLE_WRITE = 1'b0;
  localparam logic KIND_SAMPLE      = 1'b1;

  localparam logic [SLOT_W-1:0] MOMENT_UNCORR_REFL = 2'd3;
  localparam logic [TBL_W-1:0]  TBL_REFL           = 2'd0;

  localparam logic [CFG_IDX_W-1:0] REG_OUT_GATE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_SPACING     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SPACING    = 2'd2;

  localparam logic [OGC_W-1:0]     OGC_RESET     = 13'd1024;
  localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd4000;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] moment;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] wvalue;
    logic              final_gate;
  } rgrr_item_t;

  typedef struct packed {
    logic [OUT_GATE_W-1:0] gate;
    logic [SLOT_W-1:0]     slot;
    logic [BYTE_W-1:0]     value;
    logic                  last;
    logic                  clipped;
  } rgrr_result_t;

endpackage
`default_nettype wire

// File: hw/rtl/rgrr_front.sv
`default_nettype none
module rgrr_front (
  input  wire logic [rgrr_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [rgrr_pkg::IN_TUSER_W-1:0] in_tuser,
  input  wire logic                            in_tlast,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output rgrr_pkg::rgrr_item_t                 q_item
);
  import rgrr_pkg::*;

  logic              kind;
  logic [SLOT_W-1:0] moment;
  logic [TBL_W-1:0]  tbl;

  assign kind   = in_tuser[0];
  assign moment = in_tuser[2:1];
  assign tbl    = (moment == MOMENT_UNCORR_REFL) ? TBL_REFL : TBL_W'(moment);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.kind       = kind;
    q_item.moment     = moment;
    q_item.addr       = (kind == KIND_TABLE_WRITE) ? {tbl, in_tdata[7:0]}
                                                   : {tbl, in_tdata[23:16]};
    q_item.wvalue     = in_tdata[15:8];
    q_item.final_gate = in_tlast && (kind == KIND_SAMPLE);
  end

endmodule
`default_nettype wire

// File: hw/rtl/rgrr_queue.sv
`default_nettype none
module rgrr_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rgrr_pkg::rgrr_item_t push_item,
  input  wire logic           pop,
  output rgrr_pkg::rgrr_item_t head,
  output logic                full,
  output logic                empty
);
  import rgrr_pkg::*;

  rgrr_item_t         slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rgrr_back.sv
`default_nettype none
module rgrr_back #(
  parameter int MAX_OUT_GATES = rgrr_pkg::MAX_OUT_GATES_DEF,
  parameter int MAX_FANOUT    = rgrr_pkg::MAX_FANOUT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_empty,
  input  wire rgrr_pkg::rgrr_item_t           q_head,
  output logic                                q_pop,
  input  wire logic [rgrr_pkg::OGC_W-1:0]     cfg_ogc,
  input  wire logic [rgrr_pkg::SPACING_W-1:0] cfg_in_sp,
  input  wire logic [rgrr_pkg::SPACING_W-1:0] cfg_out_sp,
  input  wire logic                           out_tready,
  output logic                                out_valid,
  output rgrr_pkg::rgrr_result_t              out_res
);
  import rgrr_pkg::*;

  localparam int LIM_W  = $clog2(MAX_OUT_GATES + 1);
  localparam int CNT_W  = (LIM_W > OGC_W) ? LIM_W : OGC_W;
  localparam int K_W    = $clog2(MAX_FANOUT + 1);
  localparam int SPAN_W = SPACING_W + $clog2(MAX_FANOUT + 2);
  localparam int PROD_W = CNT_W + SPACING_W;
  localparam int DIVC_W = $clog2(EDGE_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;

  logic [BYTE_W-1:0] tab_mem [TAB_ENTRIES];
  logic              tab_we, tab_re;
  logic [BYTE_W-1:0] val_r;

  logic [SPACING_W-1:0] osp_eff, osp_r;
  logic [SPACING_W:0]   two_osp_r;
  logic [SPAN_W-1:0]    fan_span_r;
  logic [CNT_W-1:0]     limit_r;

  logic [2:0]           state_r, state_nxt;
  logic [EDGE_W-1:0]    src_r, src_nxt;
  logic [EDGE_W-1:0]    dest_r, dest_nxt;
  logic [CNT_W-1:0]     dgc_r, dgc_nxt;
  logic [EDGE_W-1:0]    diff_r, diff_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [SLOT_W-1:0]    moment_r, moment_nxt;
  logic                 fin_r, fin_nxt;
  logic                 clip_r, clip_nxt;
  logic [K_W-1:0]       k_r, k_nxt;
  logic [DIVC_W-1:0]    divc_r, divc_nxt;
  logic [SPACING_W-1:0] divrem_r, divrem_nxt;
  logic [EDGE_W-1:0]    q_r, q_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rgrr_result_t         out_res_r, out_res_nxt;

  logic [EDGE_W:0]      src_sum;
  logic [SPACING_W:0]   trial;
  logic                 trial_ge;
  logic [CNT_W-1:0]     nsel;
  logic                 out_free, last, done;

  assign osp_eff   = (cfg_out_sp == '0) ? SPACING_W'(1) : cfg_out_sp;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    osp_r      <= osp_eff;
    two_osp_r  <= {osp_eff, 1'b0};
    fan_span_r <= SPAN_W'(osp_eff) * SPAN_W'(MAX_FANOUT + 1);
    limit_r    <= (CNT_W'(cfg_ogc) > CNT_W'(MAX_OUT_GATES)) ? CNT_W'(MAX_OUT_GATES)
                                                            : CNT_W'(cfg_ogc);
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[q_head.addr] <= q_head.wvalue;
    end
    if (tab_re) begin
      val_r <= tab_mem[q_head.addr];
    end
  end

  assign src_sum  = {1'b0, src_r} + (EDGE_W + 1)'(cfg_in_sp);
  assign out_free = !out_valid_r || out_tready;
  assign trial    = {divrem_r, diff_r[EDGE_W-1]};
  assign trial_ge = (trial >= {1'b0, osp_r});
  assign nsel     = (q_r < EDGE_W'(rem_r)) ? CNT_W'(q_r) : rem_r;
  assign last     = clip_r ? (k_r == K_W'(MAX_FANOUT - 1))
                           : ((rem_r == CNT_W'(1)) || (diff_r < EDGE_W'(two_osp_r)));

  always_comb begin
    state_nxt     = state_r;
    src_nxt       = src_r;
    dest_nxt      = dest_r;
    dgc_nxt       = dgc_r;
    diff_nxt      = diff_r;
    rem_nxt       = rem_r;
    moment_nxt    = moment_r;
    fin_nxt       = fin_r;
    clip_nxt      = clip_r;
    k_nxt         = k_r;
    divc_nxt      = divc_r;
    divrem_nxt    = divrem_r;
    q_nxt         = q_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    q_pop         = 1'b0;
    tab_we        = 1'b0;
    tab_re        = 1'b0;
    done          = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          moment_nxt = q_head.moment;
          fin_nxt    = q_head.final_gate;
          if (q_head.kind == KIND_TABLE_WRITE) begin
            tab_we = 1'b1;
          end else begin
            tab_re    = 1'b1;
            src_nxt   = src_sum[EDGE_W] ? '1 : src_sum[EDGE_W-1:0];
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        diff_nxt  = (src_r >= dest_r) ? (src_r - dest_r) : '0;
        rem_nxt   = (dgc_r < limit_r) ? (limit_r - dgc_r) : '0;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if ((rem_r == '0) || (diff_r < EDGE_W'(osp_r))) begin
          done = 1'b1;
        end else begin
          clip_nxt  = (rem_r > CNT_W'(MAX_FANOUT)) && (diff_r >= EDGE_W'(fan_span_r));
          k_nxt     = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_res_nxt.gate    = dgc_r[OUT_GATE_W-1:0];
          out_res_nxt.slot    = moment_r;
          out_res_nxt.value   = val_r;
          out_res_nxt.last    = last;
          out_res_nxt.clipped = clip_r;
          dgc_nxt  = dgc_r + 1'b1;
          diff_nxt = diff_r - EDGE_W'(osp_r);
          dest_nxt = dest_r + EDGE_W'(osp_r);
          rem_nxt  = rem_r - 1'b1;
          k_nxt    = k_r + 1'b1;
          if (last) begin
            if (clip_r) begin
              divc_nxt   = '0;
              divrem_nxt = '0;
              q_nxt      = '0;
              state_nxt  = S_DIV;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
      S_DIV: begin
        divrem_nxt = trial_ge ? SPACING_W'(trial - {1'b0, osp_r}) : trial[SPACING_W-1:0];
        q_nxt      = {q_r[EDGE_W-2:0], trial_ge};
        diff_nxt   = {diff_r[EDGE_W-2:0], 1'b0};
        divc_nxt   = divc_r + 1'b1;
        if (divc_r == '1) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(nsel) * PROD_W'(osp_r);
        dgc_nxt   = dgc_r + nsel;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        dest_nxt = dest_r + EDGE_W'(prod_r);
        done     = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = S_IDLE;
      if (fin_r) begin
        src_nxt  = '0;
        dest_nxt = '0;
        dgc_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      src_r       <= '0;
      dest_r      <= '0;
      dgc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      src_r       <= src_nxt;
      dest_r      <= dest_nxt;
      dgc_r       <= dgc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diff_r    <= diff_nxt;
    rem_r     <= rem_nxt;
    moment_r  <= moment_nxt;
    fin_r     <= fin_nxt;
    clip_r    <= clip_nxt;
    k_r       <= k_nxt;
    divc_r    <= divc_nxt;
    divrem_r  <= divrem_nxt;
    q_r       <= q_nxt;
    prod_r    <= prod_nxt;
    out_res_r <= out_res_nxt;
  end

endmodule
`default_nettype wire

// File: hw/rtl/radar_gate_resample_rescale.sv
`default_nettype none
// Channel   Direction  tdata (low bit up)                    tuser (low bit up)          tlast
// in_       slave      table_index, table_value, sample      kind, moment                final_gate
// out_      master     out_gate, value, zero pad             field_slot, fanout_clipped  run_last
// cfg_      write      cfg_addr selects the register, cfg_wdata carries its value
//
// A table write completes in S_IDLE. A sample passes S_CALC and S_CHK, then S_EMIT puts
// each result in the single output register whenever that register is free. A sample whose
// gates exceed the fanout limit adds the bit-serial divider and the edge multiply.
// Reset is synchronous and needs no clearing pass; table entries are undefined until written.
// A four-entry queue keeps accepting items, until it is full, while the output register waits on out_tready.
module radar_gate_resample_rescale #(
  parameter int MAX_OUT_GATES = rgrr_pkg::MAX_OUT_GATES_DEF,
  parameter int MAX_FANOUT    = rgrr_pkg::MAX_FANOUT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rgrr_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  wire logic [rgrr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // table_index [7:0], table_value [15:8], sample [23:16]
  input  wire logic [rgrr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind [0], moment [2:1]
  input  wire logic [rgrr_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  wire logic                             in_tlast,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_gate [11:0], value [19:12], zero [23:20]
  output logic [rgrr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // field_slot [1:0], fanout_clipped [2]
  output logic [rgrr_pkg::OUT_TUSER_W-1:0]      out_tuser,
  output logic                                  out_tlast
);
  import rgrr_pkg::*;

  logic [OGC_W-1:0]     ogc_r;
  logic [SPACING_W-1:0] in_sp_r;
  logic [SPACING_W-1:0] out_sp_r;

  logic         q_push, q_pop, q_full, q_empty;
  rgrr_item_t   q_item, q_head;
  rgrr_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ogc_r    <= OGC_RESET;
      in_sp_r  <= SPACING_RESET;
      out_sp_r <= SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_OUT_GATE_COUNT: ogc_r    <= cfg_wdata[OGC_W-1:0];
        REG_IN_SPACING:     in_sp_r  <= cfg_wdata;
        REG_OUT_SPACING:    out_sp_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  rgrr_front u_front (
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  rgrr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  rgrr_back #(
    .MAX_OUT_GATES (MAX_OUT_GATES),
    .MAX_FANOUT    (MAX_FANOUT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg_ogc    (ogc_r),
    .cfg_in_sp  (in_sp_r),
    .cfg_out_sp (out_sp_r),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (res)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res.value, res.gate};
  assign out_tuser = {res.clipped, res.slot};
  assign out_tlast = res.last;

endmodule
`default_nettype wire

// File: hw/rtl/rgrr_check.sv
`default_nettype none
module rgrr_check (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [rgrr_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [rgrr_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input wire logic                              out_tlast
);
  import rgrr_pkg::*;

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_reset_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Within one run the results come back to back on consecutive output gates.
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid &&
      (out_tdata[OUT_GATE_W-1:0] == $past(out_tdata[OUT_GATE_W-1:0]) + 12'd1) &&
      (out_tuser == $past(out_tuser)))
    else $error("run of results broken");

endmodule

bind radar_gate_resample_rescale rgrr_check u_check (.*);
`default_nettype wire

// File: dv/rgrr_gate_checker.sv
`timescale 1ns / 1ps
module rgrr_gate_checker
  import rgrr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   in_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  input  logic                   out_tlast,
  output int                     err_count,
  output int                     pending
);

  logic [BYTE_W-1:0]    lut_shadow [TAB_ENTRIES];
  logic [OGC_W-1:0]     gate_limit_reg;
  logic [SPACING_W-1:0] in_spacing_reg;
  logic [SPACING_W-1:0] out_spacing_reg;
  int unsigned          gates_used;
  logic [EDGE_W-1:0]    src_edge;
  logic [EDGE_W-1:0]    dst_edge;
  rgrr_result_t         gate_writes_due [$];

  initial err_count = 0;
  initial pending = 0;

  task automatic log_gate_mismatch(input string msg);
    $display("[%0t] gate write mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic resample_item(input logic kind, input logic [SLOT_W-1:0] moment,
                               input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] val,
                               input logic [BYTE_W-1:0] smp, input logic fin);
    logic [TBL_W-1:0] tsel;
    longint unsigned  sum, lim, osp, avail, n, emit;
    logic             clip;
    rgrr_result_t     r;
    tsel = (moment == MOMENT_UNCORR_REFL) ? TBL_REFL : TBL_W'(moment);
    if (kind == KIND_TABLE_WRITE) begin
      lut_shadow[{tsel, idx}] = val;
      return;
    end
    sum = 64'(src_edge) + 64'(in_spacing_reg);
    src_edge = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
    lim = (64'(gate_limit_reg) > 64'(MAX_OUT_GATES_DEF)) ? 64'(MAX_OUT_GATES_DEF)
                                                         : 64'(gate_limit_reg);
    osp = (out_spacing_reg == '0) ? 64'd1 : 64'(out_spacing_reg);
    avail = (src_edge >= dst_edge) ? 64'(src_edge - dst_edge) / osp : 64'd0;
    n = (64'(gates_used) < lim) ? lim - 64'(gates_used) : 64'd0;
    if (avail < n) n = avail;
    emit = (n > 64'(MAX_FANOUT_DEF)) ? 64'(MAX_FANOUT_DEF) : n;
    clip = (n > 64'(MAX_FANOUT_DEF));
    for (int k = 0; k < int'(emit); k++) begin
      r.gate    = OUT_GATE_W'(64'(gates_used) + 64'(k));
      r.slot    = moment;
      r.value   = lut_shadow[{tsel, smp}];
      r.last    = (k == int'(emit) - 1);
      r.clipped = clip;
      gate_writes_due.push_back(r);
    end
    gates_used = gates_used + 32'(n);
    dst_edge = dst_edge + 32'(n * osp);
    if (fin) begin
      gates_used = 0;
      src_edge = '0;
      dst_edge = '0;
    end
  endtask

  task automatic check_gate_write();
    rgrr_result_t got, want;
    got.gate    = out_tdata[OUT_GATE_W-1:0];
    got.value   = out_tdata[OUT_GATE_W +: BYTE_W];
    got.slot    = out_tuser[SLOT_W-1:0];
    got.clipped = out_tuser[SLOT_W];
    got.last    = out_tlast;
    if (gate_writes_due.size() == 0) begin
      log_gate_mismatch($sformatf("unexpected gate %0d slot %0d value %02h", got.gate,
                                  got.slot, got.value));
      return;
    end
    want = gate_writes_due.pop_front();
    if (got !== want)
      log_gate_mismatch($sformatf(
        "got gate %0d slot %0d value %02h last %0b clip %0b, want %0d %0d %02h %0b %0b",
        got.gate, got.slot, got.value, got.last, got.clipped,
        want.gate, want.slot, want.value, want.last, want.clipped));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      gate_limit_reg  = OGC_RESET;
      in_spacing_reg  = SPACING_RESET;
      out_spacing_reg = SPACING_RESET;
      gates_used      = 0;
      src_edge        = '0;
      dst_edge        = '0;
      gate_writes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_OUT_GATE_COUNT: gate_limit_reg = cfg_wdata[OGC_W-1:0];
          REG_IN_SPACING:     in_spacing_reg = cfg_wdata;
          REG_OUT_SPACING:    out_spacing_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        resample_item(in_tuser[0], in_tuser[SLOT_W:1], in_tdata[BYTE_W-1:0],
                      in_tdata[BYTE_W +: BYTE_W], in_tdata[2*BYTE_W +: BYTE_W], in_tlast);
      if (out_tvalid && out_tready)
        check_gate_write();
    end
    pending <= gate_writes_due.size();
  end

endmodule

// File: dv/tb_radar_gate_resample_rescale.sv
`timescale 1ns / 1ps
module tb_radar_gate_resample_rescale;
  import rgrr_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 300;

  localparam logic [SLOT_W-1:0]    MOM_REFL  = 2'd0;
  localparam logic [SLOT_W-1:0]    MOM_VEL   = 2'd1;
  localparam logic [SLOT_W-1:0]    MOM_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   out_tlast;

  int   err_count;
  int   pending;
  logic calm = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   cyc_cnt = 0;

  bit               fill_seen [NUM_TABLES][TABLE_DEPTH];
  logic [BYTE_W-1:0] fill_list [NUM_TABLES][TABLE_DEPTH];
  int               fill_cnt [NUM_TABLES];

  always #1 clk = ~clk;

  radar_gate_resample_rescale u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  rgrr_gate_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .err_count  (err_count),
    .pending    (pending)
  );

  // The one long hold lets the input queue fill while the sender keeps offering items.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 18);
    end
  end

  task automatic send_item(input logic kind, input logic [SLOT_W-1:0] moment,
                           input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] val,
                           input logic [BYTE_W-1:0] smp, input logic fin);
    int t;
    t = (moment == MOMENT_UNCORR_REFL) ? int'(TBL_REFL) : int'(moment);
    if (!calm && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    if (kind == KIND_TABLE_WRITE && !fill_seen[t][idx]) begin
      fill_seen[t][idx] = 1'b1;
      fill_list[t][fill_cnt[t]] = idx;
      fill_cnt[t]++;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {smp, val, idx};
    in_tuser  <= {moment, kind};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic random_items(input int count, input int final_pct);
    logic [SLOT_W-1:0] m;
    logic [BYTE_W-1:0] idx, val, smp;
    int                t;
    for (int i = 0; i < count; i++) begin
      m   = SLOT_W'($urandom_range(3));
      t   = (m == MOMENT_UNCORR_REFL) ? int'(TBL_REFL) : int'(m);
      idx = BYTE_W'($urandom_range(255));
      val = BYTE_W'($urandom_range(255));
      smp = BYTE_W'($urandom_range(255));
      if ($urandom_range(99) < 20) begin
        send_item(KIND_TABLE_WRITE, m, idx, val, smp, 1'($urandom_range(1)));
      end else begin
        smp = fill_list[t][$urandom_range(fill_cnt[t] - 1)];
        send_item(KIND_SAMPLE, m, idx, val, smp, ($urandom_range(99) < final_pct));
      end
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_regs(input int gate_count, input int in_sp, input int out_sp,
                          input bit poke_spare);
    drain();
    cfg_write(REG_OUT_GATE_COUNT, CFG_DATA_W'(gate_count));
    cfg_write(REG_IN_SPACING, CFG_DATA_W'(in_sp));
    cfg_write(REG_OUT_SPACING, CFG_DATA_W'(out_sp));
    if (poke_spare) cfg_write(REG_SPARE, 16'hFFFF);
    cfg_we <= 1'b0;
  endtask

  initial begin
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Table loads, including a shared-table write that also carries tlast, then samples from every table.
    send_item(KIND_TABLE_WRITE, MOM_REFL, 8'h00, 8'hFF, 8'hFF, 1'b0);
    send_item(KIND_TABLE_WRITE, MOM_REFL, 8'hFF, 8'h00, 8'h00, 1'b0);
    send_item(KIND_TABLE_WRITE, MOM_VEL, 8'h00, 8'hA5, 8'h00, 1'b0);
    send_item(KIND_TABLE_WRITE, MOM_VEL, 8'hFF, 8'h5A, 8'hFF, 1'b0);
    send_item(KIND_TABLE_WRITE, MOM_WIDTH, 8'h00, 8'h3C, 8'h00, 1'b0);
    send_item(KIND_TABLE_WRITE, MOM_WIDTH, 8'hFF, 8'hC3, 8'hFF, 1'b0);
    send_item(KIND_TABLE_WRITE, MOMENT_UNCORR_REFL, 8'h81, 8'h7E, 8'h00, 1'b1);
    send_item(KIND_SAMPLE, MOM_REFL, 8'hFF, 8'hFF, 8'h00, 1'b0);
    send_item(KIND_SAMPLE, MOM_VEL, 8'h00, 8'h00, 8'hFF, 1'b0);
    send_item(KIND_SAMPLE, MOM_WIDTH, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(KIND_SAMPLE, MOMENT_UNCORR_REFL, 8'h00, 8'h00, 8'hFF, 1'b0);
    send_item(KIND_SAMPLE, MOMENT_UNCORR_REFL, 8'h00, 8'h00, 8'h81, 1'b0);
    send_item(KIND_SAMPLE, MOM_REFL, 8'h00, 8'h00, 8'h81, 1'b0);
    send_item(KIND_SAMPLE, MOM_VEL, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(KIND_SAMPLE, MOM_WIDTH, 8'h00, 8'h00, 8'hFF, 1'b1);
    send_item(KIND_SAMPLE, MOM_REFL, 8'h00, 8'h00, 8'hFF, 1'b0);
    in_tvalid <= 1'b0;

    set_regs(1024, 4000, 4000, 1'b0);
    calm <= 1'b1;
    hold_req <= 1'b1;
    random_items(60, 5);
    calm <= 1'b0;

    set_regs(4096, 65535, 1, 1'b0);
    random_items(30, 15);

    set_regs(8191, 3000, 1000, 1'b0);
    random_items(50, 4);

    set_regs(0, 4000, 4000, 1'b1);
    random_items(15, 10);

    set_regs(300, 12, 0, 1'b0);
    random_items(50, 3);

    set_regs(2048, 0, 500, 1'b0);
    random_items(15, 0);

    set_regs(1, 65535, 65535, 1'b0);
    random_items(25, 25);

    set_regs(40, 1000, 3000, 1'b0);
    random_items(60, 3);

    set_regs(4096, 1, 1, 1'b0);
    calm <= 1'b1;
    random_items(40, 2);
    calm <= 1'b0;

    set_regs(4096, 17, 5, 1'b0);
    random_items(60, 2);

    drain();
    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
